// File: rtl/phkt_pkg.sv
// Types and codes shared by the peer heartbeat keepalive table.
// Depends on nothing. Used by every module of the block.
package phkt_pkg;

	localparam int ADDR_W = 4;

	localparam logic [2:0] OP_ADD     = 3'd0;
	localparam logic [2:0] OP_BEAT    = 3'd1;
	localparam logic [2:0] OP_TICK    = 3'd2;
	localparam logic [2:0] OP_REM_EP  = 3'd3;
	localparam logic [2:0] OP_REM_ID  = 3'd4;
	localparam logic [2:0] OP_LOOK_EP = 3'd5;
	localparam logic [2:0] OP_LOOK_ID = 3'd6;
	localparam logic [2:0] OP_NONE    = 3'd7;

	localparam logic [3:0] K_ADDED        = 4'd0;
	localparam logic [3:0] K_DUP          = 4'd1;
	localparam logic [3:0] K_FULL         = 4'd2;
	localparam logic [3:0] K_BEAT_OK      = 4'd3;
	localparam logic [3:0] K_BEAT_UNEXP   = 4'd4;
	localparam logic [3:0] K_BEAT_UNKNOWN = 4'd5;
	localparam logic [3:0] K_PROBE        = 4'd6;
	localparam logic [3:0] K_TIMEOUT      = 4'd7;
	localparam logic [3:0] K_REMOVED      = 4'd8;
	localparam logic [3:0] K_NOTFOUND     = 4'd9;
	localparam logic [3:0] K_FOUND        = 4'd10;
	localparam logic [3:0] K_TICKDONE     = 4'd11;

	localparam logic [1:0] REG_BEAT_INTERVAL = 2'd0;
	localparam logic [1:0] REG_RETRY_LIMIT   = 2'd1;
	localparam logic [1:0] REG_DROP_AFTER    = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] peer_ip;
		logic [15:0] peer_port;
		logic [15:0] peer_id;
		logic [15:0] delta_ms;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] result_id;
		logic [31:0] result_ip;
		logic [15:0] result_port;
		logic [31:0] ping_ms;
		logic [31:0] stamp_ms;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] ip;
		logic [15:0] port;
		logic [15:0] id;
		logic [31:0] last_beat;
		logic [31:0] probe_time;
		logic        waiting;
		logic [3:0]  retries;
		logic [31:0] ping;
	} ent_t;

	typedef struct packed {
		logic [2:0]  op;
		logic        scan;
		logic        write_here;
		logic        hit;
		logic [31:0] now;
		logic [31:0] ip;
		logic [15:0] port;
		logic [15:0] id;
		logic [15:0] new_id;
		logic [15:0] beat_interval;
		logic [3:0]  retry_limit;
		logic [19:0] drop_after;
	} head_ctl_t;

	typedef struct packed {
		logic       emit;
		logic       match;
		logic [3:0] kind;
	} head_res_t;

endpackage

// File: rtl/phkt_cell.sv
// One slot of the peer ring: holds a table entry and takes its neighbor's
// entry on every shift. Depends on phkt_pkg.
module phkt_cell
	import phkt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic shift,
	input  ent_t d,
	output ent_t q
);

	logic valid_q;
	ent_t ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			ent_q <= d;
		end
	end

	always_comb begin
		q = ent_q;
		q.valid = valid_q;
	end

endmodule

// File: rtl/phkt_head.sv
// Head of the ring: evaluates the entry leaving slot zero for the current
// operation and produces the entry that re-enters at the tail. Depends on phkt_pkg.
module phkt_head
	import phkt_pkg::*;
(
	input  head_ctl_t ctl,
	input  ent_t      cur,
	output ent_t      nxt,
	output head_res_t res
);

	logic        ep_match;
	logic        id_match;
	logic [31:0] elapsed;
	logic [20:0] backoff;

	assign ep_match = cur.valid && (cur.ip == ctl.ip) && (cur.port == ctl.port) && !ctl.hit;
	assign id_match = cur.valid && (cur.id == ctl.id) && !ctl.hit;
	assign elapsed  = ctl.now - cur.last_beat;
	assign backoff  = 21'(ctl.beat_interval) * 21'({1'b0, cur.retries} + 5'd1);

	always_comb begin
		nxt = cur;
		res = '0;
		if (ctl.write_here) begin
			nxt.valid      = 1'b1;
			nxt.ip         = ctl.ip;
			nxt.port       = ctl.port;
			nxt.id         = ctl.new_id;
			nxt.last_beat  = ctl.now;
			nxt.probe_time = '0;
			nxt.waiting    = 1'b0;
			nxt.retries    = '0;
			nxt.ping       = '0;
			res.match      = 1'b1;
			res.kind       = K_ADDED;
		end else if (ctl.scan) begin
			unique case (ctl.op)
				OP_ADD: begin
					if (ep_match) begin
						res.match = 1'b1;
						res.kind  = K_DUP;
					end
				end
				OP_BEAT: begin
					if (ep_match) begin
						res.match = 1'b1;
						if (cur.waiting) begin
							nxt.ping      = ctl.now - cur.probe_time;
							nxt.last_beat = ctl.now;
							nxt.waiting   = 1'b0;
							nxt.retries   = '0;
							res.kind      = K_BEAT_OK;
						end else begin
							res.kind = K_BEAT_UNEXP;
						end
					end
				end
				OP_REM_EP, OP_REM_ID: begin
					if ((ctl.op == OP_REM_EP) ? ep_match : id_match) begin
						res.match = 1'b1;
						res.kind  = K_REMOVED;
						nxt.valid = 1'b0;
					end
				end
				OP_LOOK_EP, OP_LOOK_ID: begin
					if ((ctl.op == OP_LOOK_EP) ? ep_match : id_match) begin
						res.match = 1'b1;
						res.kind  = K_FOUND;
					end
				end
				OP_TICK: begin
					if (cur.valid && (elapsed >= {16'd0, ctl.beat_interval})) begin
						if ((elapsed >= {12'd0, ctl.drop_after}) ||
						    (cur.retries > ctl.retry_limit)) begin
							nxt.valid = 1'b0;
							res.emit  = 1'b1;
							res.kind  = K_TIMEOUT;
						end else if (!cur.waiting || (elapsed >= {11'd0, backoff})) begin
							if (cur.retries == 4'd0) begin
								nxt.probe_time = ctl.now;
							end
							nxt.waiting = 1'b1;
							if (cur.retries != 4'd15) begin
								nxt.retries = cur.retries + 4'd1;
							end
							res.emit = 1'b1;
							res.kind = K_PROBE;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/peer_heartbeat_keepalive_table.sv
// Channel   | Direction | Handshake          | Payload
// in        | input     | in_valid/in_stall  | in_data (in_item_t)
// out       | output    | out_valid/out_stall| out_data (out_item_t)
// config    | input     | APB psel/penable   | paddr, pwdata, prdata
//
// Every item except OP_NONE rotates the whole ring once, then emits
// the final beat. An add that stores a peer needs a second rotation.
// A stalled output freezes the ring when the head has a beat to emit, until the pending beat leaves.
// Reset clears the slot valid bits, the id counter and the clock; no clearing pass.
// Top level: sequencer, configuration registers and output register around
// the cell ring. Depends on phkt_pkg, phkt_cell and phkt_head.
module peer_heartbeat_keepalive_table
	import phkt_pkg::*;
#(
	parameter int MAX_PEERS = 16
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PEERS - 1);

	state_t state_q, state_d;
	in_item_t item_q;
	logic [31:0] now_q;
	logic [15:0] next_id_q;
	logic [15:0] beat_interval_q;
	logic [3:0]  retry_limit_q;
	logic [19:0] drop_after_q;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] free_idx_q;
	logic free_found_q;
	logic hit_q;
	logic [3:0] hit_kind_q;
	logic [15:0] hit_id_q;
	logic [31:0] hit_ip_q;
	logic [15:0] hit_port_q;
	logic [31:0] hit_ping_q;
	logic out_valid_q;
	out_item_t out_q;

	ent_t ring [MAX_PEERS];
	ent_t head_nxt;
	head_ctl_t ctl;
	head_res_t res;

	logic accept, out_free, advance, pass_end, out_load, hit_now, free_now;
	out_item_t out_d;
	logic [3:0] miss_kind;

	assign pready   = 1'b1;
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_interval_q <= 16'd1000;
			retry_limit_q   <= 4'd5;
			drop_after_q    <= 20'd10000;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				REG_BEAT_INTERVAL: beat_interval_q <= pwdata[15:0];
				REG_RETRY_LIMIT:   retry_limit_q   <= pwdata[3:0];
				REG_DROP_AFTER:    drop_after_q    <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_BEAT_INTERVAL: prdata = {16'd0, beat_interval_q};
			REG_RETRY_LIMIT:   prdata = {28'd0, retry_limit_q};
			REG_DROP_AFTER:    prdata = {12'd0, drop_after_q};
			default:           prdata = '0;
		endcase
	end

	// Cell ring: slot i takes slot i+1, the tail takes the head's result.
	for (genvar i = 0; i < MAX_PEERS; i++) begin : g_cell
		ent_t d;
		if (i == MAX_PEERS - 1) begin : g_tail
			assign d = head_nxt;
		end else begin : g_mid
			assign d = ring[i+1];
		end
		phkt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (advance),
			.d     (d),
			.q     (ring[i])
		);
	end

	always_comb begin
		ctl = '0;
		ctl.op            = item_q.op;
		ctl.scan          = (state_q == ST_SCAN);
		ctl.write_here    = (state_q == ST_WRITE) && (cnt_q == free_idx_q);
		ctl.hit           = hit_q;
		ctl.now           = now_q;
		ctl.ip            = item_q.peer_ip;
		ctl.port          = item_q.peer_port;
		ctl.id            = item_q.peer_id;
		ctl.new_id        = next_id_q;
		ctl.beat_interval = beat_interval_q;
		ctl.retry_limit   = retry_limit_q;
		ctl.drop_after    = drop_after_q;
	end

	phkt_head u_head (
		.ctl(ctl),
		.cur(ring[0]),
		.nxt(head_nxt),
		.res(res)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (in_data.op != OP_NONE)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (pass_end) begin
					if ((item_q.op == OP_ADD) && !hit_now && free_now) begin
						state_d = ST_WRITE;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_WRITE: begin
				if (pass_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		unique case (item_q.op)
			OP_ADD:  miss_kind = K_FULL;
			OP_BEAT: miss_kind = K_BEAT_UNKNOWN;
			OP_TICK: miss_kind = K_TICKDONE;
			default: miss_kind = K_NOTFOUND;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		advance  = ((state_q == ST_SCAN) || (state_q == ST_WRITE)) && (!res.emit || out_free);
		pass_end = advance && (cnt_q == LAST_IDX);
		hit_now  = hit_q || (advance && res.match);
		free_now = free_found_q || !ring[0].valid;
		out_load = 1'b0;
		out_d    = '0;
		out_d.stamp_ms = now_q;
		if (advance && res.emit) begin
			out_load          = 1'b1;
			out_d.kind        = res.kind;
			out_d.result_id   = head_nxt.id;
			out_d.result_ip   = head_nxt.ip;
			out_d.result_port = head_nxt.port;
			out_d.ping_ms     = head_nxt.ping;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_load   = 1'b1;
			out_d.last = 1'b1;
			if (hit_q) begin
				out_d.kind        = hit_kind_q;
				out_d.result_id   = hit_id_q;
				out_d.result_ip   = hit_ip_q;
				out_d.result_port = hit_port_q;
				out_d.ping_ms     = hit_ping_q;
			end else begin
				out_d.kind = miss_kind;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			now_q        <= '0;
			next_id_q    <= '0;
			cnt_q        <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				cnt_q        <= '0;
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
				if (in_data.op == OP_TICK) begin
					now_q <= now_q + {16'd0, in_data.delta_ms};
				end
			end else if (advance) begin
				cnt_q <= pass_end ? '0 : cnt_q + IDX_W'(1);
				if (res.match) begin
					hit_q <= 1'b1;
				end
				if ((state_q == ST_SCAN) && !ring[0].valid) begin
					free_found_q <= 1'b1;
				end
				if (ctl.write_here) begin
					next_id_q <= next_id_q + 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
		if (out_load) begin
			out_q <= out_d;
		end
		if (advance && (state_q == ST_SCAN) && !ring[0].valid && !free_found_q) begin
			free_idx_q <= cnt_q;
		end
		if (advance && res.match) begin
			hit_kind_q <= res.kind;
			hit_id_q   <= head_nxt.id;
			hit_ip_q   <= head_nxt.ip;
			hit_port_q <= head_nxt.port;
			hit_ping_q <= head_nxt.ping;
		end
	end

endmodule

// File: rtl/phkt_checker.sv
// Port-level checks for the peer heartbeat keepalive table, bound to the top.
// Depends on phkt_pkg.
module phkt_port_checks
	import phkt_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("stalled output beat changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_data.op != OP_NONE) |=> in_stall)
		else $error("input taken again before the item finished");

	a_tickdone_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.kind == K_TICKDONE) |-> out_data.last)
		else $error("tick done must close the item");

	a_mid_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> (out_data.kind == K_PROBE) ||
			(out_data.kind == K_TIMEOUT))
		else $error("only tick reports may precede the final beat");

endmodule

bind peer_heartbeat_keepalive_table phkt_port_checks u_phkt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.in_data  (in_data),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);
